>>> hw/rtl/bfa_pkg.sv
// Shared types, constants and helper functions for the bitmap frame allocator.
// Used by the channel interfaces, the map memory, the engine and the top level.
// No dependencies.
package bfa_pkg;

  // Map geometry and block size
  localparam int MapWords   = 1024;
  localparam int BlockBytes = 4096;   // power of two, 1024 to 65536
  localparam int WordBits   = 32;
  localparam int BitIdxW    = 5;
  localparam int MapIdxW    = (MapWords > 1) ? $clog2(MapWords) : 1;
  localparam int FrameW     = MapIdxW + BitIdxW;
  localparam int MapBits    = MapWords * WordBits;
  localparam int CapBlocks  = (MapBits < 32768) ? MapBits : 32768;
  localparam int BlockShift = $clog2(BlockBytes);
  localparam int KbShift    = BlockShift - 10;

  // Field widths
  localparam int ReqTypeW = 2;
  localparam int AddrW    = 32;
  localparam int BlkW     = AddrW - BlockShift;
  localparam int BAddrW   = 27;
  localparam int StatusW  = 2;
  localparam int CntW     = 16;
  localparam int WordCntW = CntW + 1;
  localparam int KbW      = 18;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 18;

  localparam logic [CntW-1:0] ReservedReset = CntW'(512);

  typedef enum logic [ReqTypeW-1:0] {
    ReqInit  = 2'd0,
    ReqAlloc = 2'd1,
    ReqFree  = 2'd2,
    ReqNone  = 2'd3
  } req_e;

  typedef enum logic [StatusW-1:0] {
    StatOk      = 2'd0,
    StatOom     = 2'd1,
    StatAlready = 2'd2,
    StatRange   = 2'd3
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegMemSizeKb      = 1'b0,
    RegReservedBlocks = 1'b1
  } cfg_reg_e;

  // Access to the used-bit map: one read port, one write port
  typedef struct packed {
    logic                rd_en;
    logic [MapIdxW-1:0]  rd_addr;
    logic                wr_en;
    logic [MapIdxW-1:0]  wr_addr;
    logic [WordBits-1:0] wr_data;
  } bfa_mem_req_t;

  // One result item as produced by the engine
  typedef struct packed {
    logic [BAddrW-1:0] block_address;
    status_e           status;
    logic [CntW-1:0]   free_count;
    logic [CntW-1:0]   total_count;
  } bfa_res_t;

  // Map word written by init: a block is free when reserved <= n < total
  function automatic logic [WordBits-1:0] init_word(input logic [MapIdxW-1:0] idx,
                                                    input logic [CntW-1:0]    total,
                                                    input logic [CntW-1:0]    resv);
    logic [31:0]         n;
    logic [WordBits-1:0] w;
    for (int i = 0; i < WordBits; i++) begin
      n    = 32'({idx, BitIdxW'(i)});
      w[i] = ~((n >= 32'(resv)) && (n < 32'(total)));
    end
    return w;
  endfunction

endpackage

>>> hw/rtl/bfa_if.sv
// Request and result channel interfaces of the bitmap frame allocator.
// Depends on bfa_pkg for field widths.
interface bfa_req_if;
  import bfa_pkg::*;
  logic                valid;
  logic                ready;
  logic [ReqTypeW-1:0] req_type;
  logic [AddrW-1:0]    address;

  modport source (output valid, output req_type, output address, input ready);
  modport sink   (input valid, input req_type, input address, output ready);
endinterface

interface bfa_rsp_if;
  import bfa_pkg::*;
  logic               valid;
  logic               ready;
  logic [BAddrW-1:0]  block_address;
  logic [StatusW-1:0] status;
  logic [CntW-1:0]    free_count;
  logic [CntW-1:0]    total_count;

  modport source (output valid, output block_address, output status,
                  output free_count, output total_count, input ready);
  modport sink   (input valid, input block_address, input status,
                  input free_count, input total_count, output ready);
endinterface

>>> hw/rtl/bfa_map_ram.sv
// Used-bit map storage: one word per 32 blocks, synchronous read.
// Depends on bfa_pkg for geometry and the access struct.
module bfa_map_ram (
  input  logic                         clk_i,
  input  bfa_pkg::bfa_mem_req_t        mem_req_i,
  output logic [bfa_pkg::WordBits-1:0] rd_data_o
);
  import bfa_pkg::*;

  logic [WordBits-1:0] mem [MapWords];
  logic [WordBits-1:0] rd_data_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (mem_req_i.wr_en) begin
      mem[mem_req_i.wr_addr] <= mem_req_i.wr_data;
    end
    if (mem_req_i.rd_en) begin
      rd_data_q <= mem[mem_req_i.rd_addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> hw/rtl/bfa_engine.sv
// Request sequencer of the frame allocator: init sweep, first-fit search, free.
// Holds the block counters and drives the map memory. Depends on bfa_pkg.
module bfa_engine (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [bfa_pkg::ReqTypeW-1:0] req_type_i,
  input  logic [bfa_pkg::AddrW-1:0]    address_i,
  input  logic [bfa_pkg::KbW-1:0]      mem_kb_i,
  input  logic [bfa_pkg::CntW-1:0]     reserved_blocks_i,
  output logic                         idle_o,
  output logic                         res_valid_o,
  output bfa_pkg::bfa_res_t            res_o,
  input  logic                         res_take_i,
  output bfa_pkg::bfa_mem_req_t        mem_req_o,
  input  logic [bfa_pkg::WordBits-1:0] rd_data_i
);
  import bfa_pkg::*;

  typedef enum logic [2:0] {
    SIdle,
    SInit,
    SSearch,
    SFreeChk,
    SDone
  } state_e;

  state_e               state_q, state_d;
  logic [MapIdxW:0]     chk_q, chk_d;
  logic [FrameW-1:0]    frame_q, frame_d;
  logic [CntW-1:0]      used_q, used_d;
  logic [CntW-1:0]      total_q, total_d;
  status_e              status_q, status_d;
  logic [BAddrW-1:0]    baddr_q, baddr_d;

  logic [KbW-1:0]                kb_blocks;
  logic [CntW-1:0]               cap_total;
  logic [CntW-1:0]               init_used;
  logic [WordCntW-1:0]           words;
  logic [MapIdxW:0]              chk_next;
  logic                          has_zero;
  logic [BitIdxW-1:0]            zero_pos;
  logic [FrameW-1:0]             search_frame;
  logic [FrameW+BlockShift-1:0]  baddr_full;
  logic [BlkW-1:0]               req_blk;
  logic [FrameW-1:0]             req_frame;
  logic                          req_range;
  logic [CntW-1:0]               used_sat;

  // Block count from installed memory, saturated at map capacity
  assign kb_blocks = mem_kb_i >> KbShift;
  assign cap_total = (kb_blocks > KbW'(CapBlocks)) ? CntW'(CapBlocks) : CntW'(kb_blocks);
  assign init_used = (reserved_blocks_i < cap_total) ? reserved_blocks_i : cap_total;

  // Number of map words that hold managed blocks
  assign words    = (WordCntW'(total_q) + WordCntW'(31)) >> BitIdxW;
  assign chk_next = chk_q + 1'b1;

  // Lowest clear bit of the word just read
  always_comb begin
    zero_pos = '0;
    for (int i = WordBits - 1; i >= 0; i--) begin
      if (!rd_data_i[i]) begin
        zero_pos = BitIdxW'(i);
      end
    end
  end
  assign has_zero     = (rd_data_i != '1);
  assign search_frame = {chk_q[MapIdxW-1:0], zero_pos};
  assign baddr_full   = {search_frame, {BlockShift{1'b0}}};

  // Block addressed by a free request
  assign req_blk   = address_i[AddrW-1:BlockShift];
  assign req_frame = FrameW'(req_blk);
  assign req_range = (32'(req_blk) >= 32'(total_q));

  // Sequencer next state and memory access
  always_comb begin
    state_d   = state_q;
    chk_d     = chk_q;
    frame_d   = frame_q;
    used_d    = used_q;
    total_d   = total_q;
    status_d  = status_q;
    baddr_d   = baddr_q;
    mem_req_o = '0;
    unique case (state_q)
      SIdle: begin
        if (start_i) begin
          baddr_d  = '0;
          status_d = StatOk;
          unique case (req_e'(req_type_i))
            ReqInit: begin
              total_d = cap_total;
              used_d  = init_used;
              chk_d   = '0;
              state_d = SInit;
            end
            ReqAlloc: begin
              if (used_q >= total_q) begin
                status_d = StatOom;
                state_d  = SDone;
              end else begin
                mem_req_o.rd_en   = 1'b1;
                mem_req_o.rd_addr = '0;
                chk_d             = '0;
                state_d           = SSearch;
              end
            end
            ReqFree: begin
              if (req_range) begin
                status_d = StatRange;
                state_d  = SDone;
              end else begin
                mem_req_o.rd_en   = 1'b1;
                mem_req_o.rd_addr = req_frame[FrameW-1:BitIdxW];
                frame_d           = req_frame;
                state_d           = SFreeChk;
              end
            end
            default: begin
              state_d = SDone;
            end
          endcase
        end
      end
      SInit: begin
        // Rewrite every map word, one a cycle
        mem_req_o.wr_en   = 1'b1;
        mem_req_o.wr_addr = chk_q[MapIdxW-1:0];
        mem_req_o.wr_data = init_word(chk_q[MapIdxW-1:0], total_q, reserved_blocks_i);
        chk_d             = chk_next;
        if (chk_q[MapIdxW-1:0] == MapIdxW'(MapWords - 1)) begin
          state_d = SDone;
        end
      end
      SSearch: begin
        // Check the word read last cycle, fetch the next one meanwhile
        if (WordCntW'(chk_q) >= words) begin
          status_d = StatOom;
          state_d  = SDone;
        end else if (has_zero) begin
          if (32'(search_frame) >= 32'(total_q)) begin
            status_d = StatOom;
          end else begin
            mem_req_o.wr_en   = 1'b1;
            mem_req_o.wr_addr = chk_q[MapIdxW-1:0];
            mem_req_o.wr_data = rd_data_i | (WordBits'(1) << zero_pos);
            used_d            = used_q + 1'b1;
            baddr_d           = BAddrW'(baddr_full);
          end
          state_d = SDone;
        end else begin
          mem_req_o.rd_en   = (32'(chk_next) < 32'(MapWords));
          mem_req_o.rd_addr = chk_next[MapIdxW-1:0];
          chk_d             = chk_next;
        end
      end
      SFreeChk: begin
        if (!rd_data_i[frame_q[BitIdxW-1:0]]) begin
          status_d = StatAlready;
        end else begin
          mem_req_o.wr_en   = 1'b1;
          mem_req_o.wr_addr = frame_q[FrameW-1:BitIdxW];
          mem_req_o.wr_data = rd_data_i & ~(WordBits'(1) << frame_q[BitIdxW-1:0]);
          if (used_q != '0) begin
            used_d = used_q - 1'b1;
          end
        end
        state_d = SDone;
      end
      SDone: begin
        if (res_take_i) begin
          state_d = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  // Hold state, counters and result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      used_q   <= '0;
      total_q  <= '0;
      chk_q    <= '0;
      status_q <= StatOk;
      frame_q  <= '0;
      baddr_q  <= '0;
    end else begin
      state_q  <= state_d;
      used_q   <= used_d;
      total_q  <= total_d;
      chk_q    <= chk_d;
      status_q <= status_d;
      frame_q  <= frame_d;
      baddr_q  <= baddr_d;
    end
  end

  // Result fields
  assign used_sat              = (used_q <= total_q) ? used_q : total_q;
  assign res_o.block_address   = baddr_q;
  assign res_o.status          = status_q;
  assign res_o.free_count      = total_q - used_sat;
  assign res_o.total_count     = total_q;
  assign res_valid_o           = (state_q == SDone);
  assign idle_o                = (state_q == SIdle);

endmodule

>>> hw/rtl/bitmap_frame_allocator_unit.sv
// Bitmap first-fit page frame allocator: top level with config registers
// and output register. Depends on bfa_pkg, bfa_if, bfa_map_ram and bfa_engine.
//
// Usage:
//   req_i carries one request item (req_type, address); rsp_o returns exactly
//   one result item per request. An item moves when valid and ready are high
//   at a rising edge of clk_i. Configuration (installed memory size in KB,
//   reserved block count) is written through cfg_we_i / cfg_idx_i / cfg_data_i
//   while idle and is used by the next init request.
// Processing, from the accepting edge to the result valid on rsp_o:
//   init     every map word rewritten, one map word per cycle
//   allocate first-fit search reads map words in turn, one
//            word a cycle from the single map read port; no read when none is free
//   free     read the word, then check and write it back
//   others   no map access
// One request is processed at a time; the next one can be accepted in the cycle
// after the result moves to the output register, while the previous result
// may still sit in the output register.
// Reset: counts clear to zero and reserved_blocks returns to 512. The map
// memory is not cleared; with zero managed blocks it is never read, and an
// init rewrites every word. When rsp_o stalls, the result holds in the
// output register and the engine then holds its own finished result.
module bitmap_frame_allocator_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  bfa_req_if.sink                      req_i,
  bfa_rsp_if.source                    rsp_o,
  input  logic                         cfg_we_i,
  input  logic [bfa_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bfa_pkg::CfgDataW-1:0] cfg_data_i
);
  import bfa_pkg::*;

  logic [KbW-1:0]      mem_kb_q;
  logic [CntW-1:0]     reserved_blocks_q;
  logic                eng_idle;
  logic                eng_valid;
  logic                eng_take;
  bfa_res_t            eng_res;
  bfa_mem_req_t        mem_req;
  logic [WordBits-1:0] rd_data;
  logic                out_valid_q;
  bfa_res_t            out_res_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_kb_q          <= '0;
      reserved_blocks_q <= ReservedReset;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        RegMemSizeKb:      mem_kb_q          <= cfg_data_i[KbW-1:0];
        RegReservedBlocks: reserved_blocks_q <= cfg_data_i[CntW-1:0];
        default: ;
      endcase
    end
  end

  assign req_i.ready = eng_idle;

  bfa_engine u_engine (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (req_i.valid && eng_idle),
    .req_type_i        (req_i.req_type),
    .address_i         (req_i.address),
    .mem_kb_i          (mem_kb_q),
    .reserved_blocks_i (reserved_blocks_q),
    .idle_o            (eng_idle),
    .res_valid_o       (eng_valid),
    .res_o             (eng_res),
    .res_take_i        (eng_take),
    .mem_req_o         (mem_req),
    .rd_data_i         (rd_data)
  );

  bfa_map_ram u_map_ram (
    .clk_i     (clk_i),
    .mem_req_i (mem_req),
    .rd_data_o (rd_data)
  );

  // Output register: load a finished item when empty or being drained
  assign eng_take = eng_valid && (!out_valid_q || rsp_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (eng_take) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (eng_take) begin
      out_res_q <= eng_res;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.block_address = out_res_q.block_address;
  assign rsp_o.status        = out_res_q.status;
  assign rsp_o.free_count    = out_res_q.free_count;
  assign rsp_o.total_count   = out_res_q.total_count;

endmodule

>>> sim/bfa_frame_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the bitmap frame allocator: snoops the request, result and register
// ports, keeps its own copy of the used-bit map and compares every result item.
// Depends on bfa_pkg and the channel interfaces in bfa_if.
module bfa_frame_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  bfa_req_if                           req_mon,
  bfa_rsp_if                           rsp_mon,
  input  logic                         cfg_we_i,
  input  logic [bfa_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bfa_pkg::CfgDataW-1:0] cfg_data_i,
  output int unsigned                  fail_cnt_o,
  output int unsigned                  pending_o,
  output int unsigned                  checked_o
);
  import bfa_pkg::*;

  // Shadow allocator state and register copies
  bit              frame_used [MapBits];
  int unsigned     frames_used;
  int unsigned     frames_managed;
  logic [KbW-1:0]  mem_kb_q;
  logic [CntW-1:0] reserved_q;

  bfa_res_t    due_results [$];
  bfa_res_t    head;
  int unsigned fail_total;
  int unsigned result_total;

  // Apply one request to the shadow map and return the result item it must give
  function automatic bfa_res_t serve_request(input req_e kind, input logic [AddrW-1:0] addr);
    bfa_res_t        res;
    longint unsigned blocks;
    int unsigned     blk;
    bit              found;
    res        = '0;
    res.status = StatOk;
    found      = 1'b0;
    blk        = 0;
    case (kind)
      ReqInit: begin
        blocks         = (longint'(mem_kb_q) * 1024) / BlockBytes;
        frames_managed = (blocks > CapBlocks) ? CapBlocks : int'(blocks);
        // free only the window between the reserve and the managed total
        for (int i = 0; i < MapBits; i++)
          frame_used[i] = !((i >= reserved_q) && (i < frames_managed));
        frames_used = (reserved_q < frames_managed) ? reserved_q : frames_managed;
      end
      ReqAlloc: begin
        // first fit over managed blocks only
        if (frames_used < frames_managed) begin
          for (int n = 0; (n < frames_managed) && !found; n++) begin
            if (!frame_used[n]) begin
              blk   = n;
              found = 1'b1;
            end
          end
        end
        if (!found) begin
          res.status = StatOom;
        end else begin
          frame_used[blk]   = 1'b1;
          frames_used++;
          res.block_address = BAddrW'(longint'(blk) * BlockBytes);
        end
      end
      ReqFree: begin
        blk = addr >> BlockShift;
        if (blk >= frames_managed) begin
          res.status = StatRange;
        end else if (!frame_used[blk]) begin
          res.status = StatAlready;
        end else begin
          frame_used[blk] = 1'b0;
          if (frames_used > 0) frames_used--;
        end
      end
      default: ;
    endcase
    res.free_count  = CntW'(frames_managed -
                           ((frames_used <= frames_managed) ? frames_used : frames_managed));
    res.total_count = CntW'(frames_managed);
    return res;
  endfunction

  function automatic void check_field(input string name, input longint unsigned want,
                                      input longint unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      fail_total++;
    end
  endfunction

  // Track registers, retire result items, then queue the prediction for a new item
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MapBits; i++) frame_used[i] = 1'b1;
      frames_used    = 0;
      frames_managed = 0;
      mem_kb_q       = '0;
      reserved_q     = ReservedReset;
      due_results.delete();
      fail_total     = 0;
      result_total   = 0;
      fail_cnt_o    <= 0;
      pending_o     <= 0;
      checked_o     <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          RegMemSizeKb:      mem_kb_q   = cfg_data_i[KbW-1:0];
          RegReservedBlocks: reserved_q = cfg_data_i[CntW-1:0];
          default: ;
        endcase
      end
      if (rsp_mon.valid && rsp_mon.ready) begin
        result_total++;
        if (due_results.size() == 0) begin
          $error("unexpected result item: status %0d, block_address 0x%0h",
                 rsp_mon.status, rsp_mon.block_address);
          fail_total++;
        end else begin
          head = due_results.pop_front();
          check_field("block_address", head.block_address, rsp_mon.block_address);
          check_field("status", head.status, rsp_mon.status);
          check_field("free_count", head.free_count, rsp_mon.free_count);
          check_field("total_count", head.total_count, rsp_mon.total_count);
        end
      end
      if (req_mon.valid && req_mon.ready)
        due_results.push_back(serve_request(req_e'(req_mon.req_type), req_mon.address));
      fail_cnt_o <= fail_total;
      pending_o  <= due_results.size();
      checked_o  <= result_total;
    end
  end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// Top of the bitmap frame allocator bench: clock, reset, request stimulus, result
// back-pressure, register writes and the verdict. Depends on bfa_pkg, bfa_if, the
// allocator RTL and bfa_frame_checker.
module tb_top;
  import bfa_pkg::*;

  localparam int ClkPeriod   = 4;
  localparam int ItemsTarget = 580;
  // longest correct quiet spell is one full map pass plus stall and gap
  localparam int StallLimit  = 8000;
  localparam int TailCycles  = 1100;

  logic                clk_i  = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  int unsigned fail_cnt;
  int unsigned pending;
  int unsigned checked;

  // stimulus bookkeeping
  logic [KbW-1:0]  cur_kb   = '0;
  logic [CntW-1:0] cur_resv = ReservedReset;
  int              total_now;
  int              grants;
  int              burst_left;
  bit              gaps_on;
  int              n_sent, n_init, n_alloc, n_free, n_other, n_settings;
  int              idle_cycles;
  logic [5:0]      stall_ph   = '0;
  logic [1:0]      stall_mode = '0;

  bfa_req_if req_ch ();
  bfa_rsp_if rsp_ch ();

  bitmap_frame_allocator_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_ch),
    .rsp_o      (rsp_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  bfa_frame_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_mon    (req_ch),
    .rsp_mon    (rsp_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending),
    .checked_o  (checked)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Result back-pressure: a new stall pattern each time the 6-bit phase counter wraps
  always @(posedge clk_i) begin
    stall_ph <= stall_ph + 6'd1;
    if (stall_ph == '0) stall_mode <= 2'($urandom_range(0, 3));
    case (stall_mode)
      2'd0:    rsp_ch.ready <= 1'b1;
      2'd1:    rsp_ch.ready <= (stall_ph % 3) != 0;
      2'd2:    rsp_ch.ready <= stall_ph[3:0] >= 4'd11;
      default: rsp_ch.ready <= 1'($urandom_range(0, 1));
    endcase
  end

  // Watchdog: give up when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("FAIL bitmap_frame_allocator_unit");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one request item, hold it until taken, then maybe pause the sender
  task automatic send_req(input req_e kind, input logic [AddrW-1:0] addr);
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.address  <= addr;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    case (kind)
      ReqInit: begin
        n_init++;
        grants    = 0;
        total_now = (int'(cur_kb >> KbShift) > CapBlocks) ? CapBlocks : int'(cur_kb >> KbShift);
      end
      ReqAlloc: begin
        n_alloc++;
        grants++;
      end
      ReqFree: n_free++;
      default: n_other++;
    endcase
    n_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 9);
      if (gaps_on) begin
        req_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
  endtask

  // Drain every outstanding result so the block is idle
  task automatic settle();
    req_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(input cfg_reg_e idx, input logic [CfgDataW-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  // New memory size and reserve, then rebuild the map
  task automatic load_geometry(input logic [KbW-1:0] kb, input logic [CfgDataW-1:0] resv_word);
    settle();
    cfg_write(RegMemSizeKb, CfgDataW'(kb));
    cfg_write(RegReservedBlocks, resv_word);
    cur_kb   = kb;
    cur_resv = resv_word[CntW-1:0];
    n_settings++;
    send_req(ReqInit, $urandom());
  endtask

  // Mostly frees of blocks granted since init, some near the edges, a few anywhere
  function automatic logic [AddrW-1:0] pick_free_addr();
    int unsigned blk;
    int unsigned base;
    base = (cur_resv < total_now) ? cur_resv : 0;
    case ($urandom_range(0, 9))
      0:       return $urandom();
      1, 2:    blk = $urandom_range(0, total_now + 4);
      default: blk = base + $urandom_range(0, grants + 1);
    endcase
    return AddrW'(blk << BlockShift) | AddrW'($urandom_range(0, BlockBytes - 1));
  endfunction

  task automatic random_item();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 2)       send_req(ReqInit, $urandom());
    else if (pick < 50) send_req(ReqAlloc, $urandom());
    else if (pick < 94) send_req(ReqFree, pick_free_addr());
    else                send_req(ReqNone, $urandom());
  endtask

  function automatic logic [KbW-1:0] pick_mem_kb();
    case ($urandom_range(0, 7))
      0, 1:    return KbW'($urandom_range(0, 256));
      2:       return KbW'($urandom_range(0, 4096));
      3:       return KbW'($urandom());
      4:       return KbW'(131072);
      5:       return '1;
      6:       return '0;
      default: return KbW'($urandom_range(4096, 131072));
    endcase
  endfunction

  function automatic logic [CfgDataW-1:0] pick_reserve();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return CfgDataW'($urandom_range(0, 48));
      2:       return CfgDataW'(ReservedReset);
      3:       return CfgDataW'($urandom());
      4:       return CfgDataW'(32768);
      default: return CfgDataW'(16'hFFFF);
    endcase
  endfunction

  initial begin
    req_ch.valid    <= 1'b0;
    req_ch.req_type <= ReqNone;
    req_ch.address  <= '0;
    cfg_we          <= 1'b0;
    cfg_idx         <= RegMemSizeKb;
    cfg_data        <= '0;
    total_now  = 0;
    grants     = 0;
    burst_left = 0;
    gaps_on    = 1'b1;
    n_sent = 0; n_init = 0; n_alloc = 0; n_free = 0; n_other = 0; n_settings = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Nothing managed before the first init
    send_req(ReqAlloc, 32'h0);
    send_req(ReqFree, 32'h0);
    send_req(ReqNone, 32'hFFFF_FFFF);
    send_req(ReqInit, 32'h0);

    // Two blocks, no reserve: block zero, exhaustion, double free, out of range
    load_geometry(18'd8, 18'd0);
    send_req(ReqAlloc, 32'h0);
    send_req(ReqAlloc, 32'h0);
    send_req(ReqAlloc, 32'h0);
    send_req(ReqFree, 32'h0000_0FFF);
    send_req(ReqFree, 32'h0000_0000);
    send_req(ReqFree, 32'h0000_2000);
    send_req(ReqFree, 32'hFFFF_FFFF);
    send_req(ReqNone, 32'h0000_1000);

    // Reserve larger than the managed total
    load_geometry(18'd8, 18'd5);
    send_req(ReqAlloc, 32'hFFFF_FFFF);
    send_req(ReqFree, 32'h0000_1000);

    // Largest size saturates at capacity
    load_geometry(18'h3FFFF, 18'd0);
    send_req(ReqAlloc, 32'h0);
    send_req(ReqFree, 32'h07FF_F000);

    // Capacity exactly, all reserved: release and regrant the top block
    load_geometry(18'd131072, 18'd32768);
    send_req(ReqAlloc, 32'h0);
    send_req(ReqFree, 32'h07FF_FFFF);
    send_req(ReqAlloc, 32'h0);

    // Random phases, each under a fresh geometry
    while (n_sent < ItemsTarget) begin
      gaps_on = $urandom_range(0, 3) != 0;
      load_geometry(pick_mem_kb(), pick_reserve());
      repeat ($urandom_range(40, 60)) begin
        if (n_sent < ItemsTarget) random_item();
      end
    end

    settle();
    repeat (TailCycles) @(posedge clk_i);
    $display("Sent %0d requests (%0d init, %0d allocate, %0d free, %0d unknown type) over %0d",
             n_init + n_alloc + n_free + n_other, n_init, n_alloc, n_free, n_other, n_settings);
    $display("register settings; %0d result items compared with the shadow map.", checked);
    if (fail_cnt == 0 && pending == 0) begin
      $display("PASS bitmap_frame_allocator_unit");
    end else begin
      $display("FAIL bitmap_frame_allocator_unit");
    end
    $finish;
  end

endmodule
